// ----- hw/rtl/srsd_pkg.sv -----
// Package: shared types, constants and opcodes of the store reload spill detector.
package srsd_pkg;

  localparam int unsigned TableEntries = 64;
  localparam int unsigned SlotIdxW     = $clog2(TableEntries);
  localparam int unsigned CfgAddrW     = 5;
  localparam int unsigned QueueDepth   = 2;
  localparam int unsigned QueuePtrW    = $clog2(QueueDepth);

  localparam logic [63:0] SpillWindowReset = 64'd1000000;

  typedef enum logic [2:0] {
    OpInstr = 3'd0,
    OpStore = 3'd1,
    OpLoad  = 3'd2,
    OpEnter = 3'd3,
    OpExit  = 3'd4,
    OpClear = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    RegSpillWindow = 2'd0,
    RegStackCheck  = 2'd1,
    RegStackLow    = 2'd2,
    RegStackHigh   = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [2:0]  operation;
    logic [63:0] mem_address;
    logic [63:0] instr_pc;
    logic [63:0] now_tick;
    logic [7:0]  access_size;
  } in_item_t;

  typedef struct packed {
    logic        spill_reload;
    logic [63:0] match_store_pc;
    logic [63:0] match_store_tick;
    logic [63:0] match_store_count;
    logic [63:0] instr_total;
    logic [63:0] region_instrs;
    logic [63:0] region_stores;
    logic [63:0] region_loads;
    logic [63:0] region_spills;
    logic [63:0] entry_instrs_snap;
    logic [63:0] entry_spills_snap;
    logic [63:0] spills_total;
  } out_item_t;

  // Classified command handed from front to back
  typedef struct packed {
    logic        is_instr;
    logic        is_store;
    logic        is_load;
    logic        is_enter;
    logic        is_exit;
    logic        is_clear;
    logic [63:0] mem_address;
    logic [63:0] instr_pc;
    logic [63:0] now_tick;
    logic [7:0]  access_size;
  } cmd_t;

  typedef struct packed {
    logic [63:0] spill_window;
    logic        stack_check;
    logic [63:0] stack_low;
    logic [63:0] stack_high;
  } cfg_t;

endpackage

// ----- hw/rtl/srsd_front.sv -----
// Front end: classify input beats and queue them for the back end.
module srsd_front import srsd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  output logic     full_o,
  input  in_item_t in_item_i,
  output logic     cmd_valid_o,
  output cmd_t     cmd_o,
  input  logic     cmd_take_i
);

  cmd_t                 q_mem [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueuePtrW:0]   cnt_q;
  cmd_t                 cls;
  logic                 do_push, do_pop;

  // Decode the opcode into command flags; at most one flag is set
  always_comb begin
    cls = '0;
    cls.mem_address = in_item_i.mem_address;
    cls.instr_pc    = in_item_i.instr_pc;
    cls.now_tick    = in_item_i.now_tick;
    cls.access_size = in_item_i.access_size;
    unique case (in_item_i.operation)
      OpInstr: cls.is_instr = 1'b1;
      OpStore: cls.is_store = 1'b1;
      OpLoad:  cls.is_load  = 1'b1;
      OpEnter: cls.is_enter = 1'b1;
      OpExit:  cls.is_exit  = 1'b1;
      OpClear: cls.is_clear = 1'b1;
      default: ;
    endcase
  end

  assign full_o      = (cnt_q == (QueuePtrW+1)'(QueueDepth));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = q_mem[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = cmd_take_i && cmd_valid_o;

  // Store the classified beat
  always_ff @(posedge clk_i) begin
    if (do_push) q_mem[wr_ptr_q] <= cls;
  end

  // Advance pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      cnt_q <= cnt_q + (QueuePtrW+1)'(do_push) - (QueuePtrW+1)'(do_pop);
    end
  end

endmodule

// ----- hw/rtl/srsd_back.sv -----
// Back end: store table, expiry, match, counters and result register.
module srsd_back import srsd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      cmd_take_o,
  output logic      empty_o,
  output out_item_t out_item_o,
  input  logic      pop_i
);

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StExec = 2'b10
  } st_e;

  st_e st_q, st_d;

  logic [TableEntries-1:0] valid_q, valid_d;
  logic [63:0] addr_q  [TableEntries];
  logic [63:0] pc_q    [TableEntries];
  logic [63:0] tick_q  [TableEntries];
  logic [7:0]  size_q  [TableEntries];
  logic [63:0] cnt_q   [TableEntries];

  cmd_t        cmd_q;
  logic [TableEntries-1:0] hit_q, expire_q;

  logic [63:0] instr_q, store_q, load_q, spill_q;
  logic [63:0] r_instr_q, r_store_q, r_load_q, r_spill_q;
  logic [63:0] snap_i_q, snap_s_q;
  logic        in_reg_q;

  out_item_t   res_q;
  logic        res_full_q;

  // Stage one: parallel compare and age check against the table
  logic [TableEntries-1:0] hit_d, expire_d;
  always_comb begin
    for (int i = 0; i < TableEntries; i++) begin
      hit_d[i]    = valid_q[i] && (addr_q[i] == cmd_i.mem_address);
      expire_d[i] = valid_q[i] && ((cmd_i.now_tick - tick_q[i]) > cfg_i.spill_window);
    end
  end

  // Oldest valid slot by a compare tree; ties keep the lower slot
  logic [SlotIdxW-1:0] ot_idx  [2*TableEntries];
  logic [63:0]         ot_tick [2*TableEntries];
  logic                ot_ok   [2*TableEntries];
  always_comb begin
    ot_idx[0]  = '0;
    ot_tick[0] = '0;
    ot_ok[0]   = 1'b0;
    for (int i = 0; i < TableEntries; i++) begin
      ot_idx[TableEntries+i]  = SlotIdxW'(i);
      ot_tick[TableEntries+i] = tick_q[i];
      ot_ok[TableEntries+i]   = valid_q[i];
    end
    for (int n = TableEntries-1; n >= 1; n--) begin
      if (ot_ok[2*n+1] && (!ot_ok[2*n] || ot_tick[2*n+1] < ot_tick[2*n])) begin
        ot_idx[n]  = ot_idx[2*n+1];
        ot_tick[n] = ot_tick[2*n+1];
        ot_ok[n]   = 1'b1;
      end else begin
        ot_idx[n]  = ot_idx[2*n];
        ot_tick[n] = ot_tick[2*n];
        ot_ok[n]   = ot_ok[2*n];
      end
    end
  end

  // Stage two: priority picks over the registered vectors
  logic [TableEntries-1:0] live;
  logic [SlotIdxW-1:0] hit_idx, free_idx, old_idx, pick_idx, ld_idx;
  logic hit_any, free_any, ld_any;
  always_comb begin
    live     = hit_q & ~expire_q;
    hit_idx  = '0; hit_any  = 1'b0;
    ld_idx   = '0; ld_any   = 1'b0;
    free_idx = '0; free_any = 1'b0;
    for (int i = TableEntries-1; i >= 0; i--) begin
      if (hit_q[i])  begin hit_any = 1'b1;  hit_idx = SlotIdxW'(i); end
      if (live[i])   begin ld_any = 1'b1;   ld_idx = SlotIdxW'(i); end
      if (!valid_q[i]) begin free_any = 1'b1; free_idx = SlotIdxW'(i); end
    end
    old_idx  = ot_idx[1];
    pick_idx = hit_any ? hit_idx : (free_any ? free_idx : old_idx);
  end

  logic is_spill;
  always_comb begin
    is_spill = ld_any && (cmd_q.now_tick > tick_q[ld_idx])
               && (cmd_q.access_size == size_q[ld_idx])
               && (!cfg_i.stack_check || (cmd_q.mem_address >= cfg_i.stack_low
                   && cmd_q.mem_address < cfg_i.stack_high));
  end

  logic exec;
  assign cmd_take_o = (st_q == StIdle) && cmd_valid_i && (!res_full_q || pop_i);
  assign exec       = (st_q == StExec);

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle: if (cmd_take_o) st_d = StExec;
      StExec: st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  // Latch command and compare vectors
  always_ff @(posedge clk_i) begin
    if (cmd_take_o) begin
      cmd_q    <= cmd_i;
      hit_q    <= hit_d;
      expire_q <= expire_d;
    end
  end

  // Write slot payload for a store
  always_ff @(posedge clk_i) begin
    if (exec && cmd_q.is_store) begin
      addr_q[pick_idx] <= cmd_q.mem_address;
      pc_q[pick_idx]   <= cmd_q.instr_pc;
      tick_q[pick_idx] <= cmd_q.now_tick;
      size_q[pick_idx] <= cmd_q.access_size;
      cnt_q[pick_idx]  <= instr_q;
    end
  end

  // Next valid bits: set on store, expire and drop the hit on load, clear on enter or clear
  always_comb begin
    valid_d = valid_q;
    if (exec) begin
      if (cmd_q.is_store) valid_d[pick_idx] = 1'b1;
      if (cmd_q.is_load) begin
        valid_d = valid_q & ~expire_q;
        if (ld_any) valid_d[ld_idx] = 1'b0;
      end
      if (cmd_q.is_enter || cmd_q.is_clear) valid_d = '0;
    end
  end

  // Next counter values
  logic [63:0] instr_n, store_n, load_n, spill_n, r_instr_n, r_store_n, r_load_n;
  logic [63:0] r_spill_n, snap_i_n, snap_s_n;
  logic        in_reg_n;
  always_comb begin
    instr_n = instr_q; store_n = store_q; load_n = load_q; spill_n = spill_q;
    r_instr_n = r_instr_q; r_store_n = r_store_q; r_load_n = r_load_q;
    r_spill_n = r_spill_q; snap_i_n = snap_i_q; snap_s_n = snap_s_q;
    in_reg_n = in_reg_q;
    if (cmd_q.is_instr) begin
      instr_n = instr_q + 64'd1;
      if (in_reg_q) r_instr_n = r_instr_q + 64'd1;
    end
    if (cmd_q.is_store) begin
      store_n = store_q + 64'd1;
      if (in_reg_q) r_store_n = r_store_q + 64'd1;
    end
    if (cmd_q.is_load) begin
      load_n = load_q + 64'd1;
      if (in_reg_q) r_load_n = r_load_q + 64'd1;
      if (is_spill) begin
        spill_n = spill_q + 64'd1;
        if (in_reg_q) r_spill_n = r_spill_q + 64'd1;
      end
    end
    if (cmd_q.is_enter) begin
      in_reg_n = 1'b1; snap_i_n = instr_q; snap_s_n = spill_q;
      r_instr_n = '0; r_store_n = '0; r_load_n = '0; r_spill_n = '0;
    end
    if (cmd_q.is_exit) in_reg_n = 1'b0;
    if (cmd_q.is_clear) begin
      instr_n = '0; store_n = '0; load_n = '0; spill_n = '0; in_reg_n = 1'b0;
      r_instr_n = '0; r_store_n = '0; r_load_n = '0; r_spill_n = '0;
      snap_i_n = '0; snap_s_n = '0;
    end
  end

  // Control state, counters and valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; valid_q <= '0; res_full_q <= 1'b0;
      instr_q <= '0; store_q <= '0; load_q <= '0; spill_q <= '0;
      r_instr_q <= '0; r_store_q <= '0; r_load_q <= '0; r_spill_q <= '0;
      snap_i_q <= '0; snap_s_q <= '0; in_reg_q <= 1'b0;
    end else begin
      st_q    <= st_d;
      valid_q <= valid_d;
      if (exec) begin
        res_full_q <= 1'b1;
        instr_q <= instr_n; store_q <= store_n; load_q <= load_n; spill_q <= spill_n;
        r_instr_q <= r_instr_n; r_store_q <= r_store_n; r_load_q <= r_load_n;
        r_spill_q <= r_spill_n; snap_i_q <= snap_i_n; snap_s_q <= snap_s_n;
        in_reg_q <= in_reg_n;
      end else if (pop_i && res_full_q) begin
        res_full_q <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (exec) begin
      res_q.spill_reload      <= cmd_q.is_load && is_spill && in_reg_q;
      res_q.match_store_pc    <= (cmd_q.is_load && is_spill) ? pc_q[ld_idx]   : '0;
      res_q.match_store_tick  <= (cmd_q.is_load && is_spill) ? tick_q[ld_idx] : '0;
      res_q.match_store_count <= (cmd_q.is_load && is_spill) ? cnt_q[ld_idx]  : '0;
      res_q.instr_total       <= instr_n;
      res_q.region_instrs     <= r_instr_n;
      res_q.region_stores     <= r_store_n;
      res_q.region_loads      <= r_load_n;
      res_q.region_spills     <= r_spill_n;
      res_q.entry_instrs_snap <= snap_i_n;
      res_q.entry_spills_snap <= snap_s_n;
      res_q.spills_total      <= spill_n;
    end
  end

  assign empty_o    = !res_full_q;
  assign out_item_o = res_q;

endmodule

// ----- hw/rtl/srsd_cfg.sv -----
// Configuration registers behind an APB-style port.
module srsd_cfg import srsd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     in_range;

  assign pready   = 1'b1;
  assign idx      = reg_idx_e'(paddr[4:3]);
  assign in_range = (paddr[2:0] == 3'd0);

  // Write on the access beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.spill_window <= SpillWindowReset;
      cfg_q.stack_check  <= 1'b0;
      cfg_q.stack_low    <= '0;
      cfg_q.stack_high   <= '0;
    end else if (psel && penable && pwrite && in_range) begin
      unique case (idx)
        RegSpillWindow: cfg_q.spill_window <= pwdata;
        RegStackCheck:  cfg_q.stack_check  <= pwdata[0];
        RegStackLow:    cfg_q.stack_low    <= pwdata;
        RegStackHigh:   cfg_q.stack_high   <= pwdata;
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    prdata = '0;
    if (in_range) begin
      unique case (idx)
        RegSpillWindow: prdata = cfg_q.spill_window;
        RegStackCheck:  prdata = {63'd0, cfg_q.stack_check};
        RegStackLow:    prdata = cfg_q.stack_low;
        RegStackHigh:   prdata = cfg_q.stack_high;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hw/rtl/store_reload_spill_detector.sv -----
// Top level: store reload spill detector.
// Each input beat passes a two-entry command queue; the back end then compares the address
// and age of all 64 table slots in parallel as it takes the beat and registers the compare
// vectors, then picks a slot, updates it and registers the result. A new item is taken only
// after the last one is through and while the single result register is free or being popped.
// Configuration registers sit at byte addresses 0, 8, 16 and 24 of a 64-bit port.
module store_reload_spill_detector import srsd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  in_item_t            in_item_i,
  output logic                empty_o,
  input  logic                pop_i,
  output out_item_t           out_item_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready
);

  cfg_t cfg;
  cmd_t cmd;
  logic cmd_valid, cmd_take;

  srsd_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg)
  );

  srsd_front u_front (
    .clk_i, .rst_ni, .push_i, .full_o, .in_item_i,
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_take_i(cmd_take)
  );

  srsd_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg), .cmd_valid_i(cmd_valid), .cmd_i(cmd),
    .cmd_take_o(cmd_take), .empty_o, .out_item_o, .pop_i
  );

endmodule

// ----- hw/rtl/srsd_checker.sv -----
// Port-level checker for the store reload spill detector, bound to the top level.
module srsd_checker import srsd_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      push_i,
  input logic      full_o,
  input logic      empty_o,
  input logic      pop_i,
  input out_item_t out_item_o
);

  // A waiting result holds until popped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> ($stable(out_item_o) && !empty_o))
    else $error("result changed while waiting");

  // Reload flag implies a spill was counted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && out_item_o.spill_reload) |-> (out_item_o.spills_total != 64'd0))
    else $error("reload without spill count");

  // Reload flag implies a spill was counted in the region
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && out_item_o.spill_reload) |-> (out_item_o.region_spills != 64'd0))
    else $error("reload without region spill");

  // Out of reset nothing is waiting
  assert property (@(posedge clk_i) $rose(rst_ni) |-> empty_o)
    else $error("result present after reset");

endmodule

bind store_reload_spill_detector srsd_checker u_srsd_checker (
  .clk_i, .rst_ni, .push_i, .full_o, .empty_o, .pop_i, .out_item_o
);
